// ----- sv/mrt_pkg.sv -----
// Memory region type table: shared types, constants and codes.
// Used by every file of the block; depends on nothing.
package mrt_pkg;

    localparam int MAX_REGIONS = 32;
    localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int ADDR_W      = 64;
    localparam int KIND_W      = 2;

    localparam logic [ADDR_W-1:0] LOW_WIN_FIRST = ADDR_W'(640 * 1024);
    localparam logic [ADDR_W-1:0] LOW_WIN_LAST  = ADDR_W'(1024 * 1024);

    localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ACPI     = 2'd3;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_CLEAR  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_LOOKUP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
        logic [KIND_W-1:0] kind;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic ins_begin;
        logic lkp_begin;
        logic ins_step;
        logic lkp_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic go_insert;
        logic go_lookup;
        logic step_done;
        logic out_free;
    } status_t;

endpackage

// ----- sv/mrt_if.sv -----
// Memory region type table: item, result and configuration channels.
// Depends on mrt_pkg for field widths.
interface mrt_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  mode;
    logic [mrt_pkg::ADDR_W-1:0]  region_start;
    logic [mrt_pkg::ADDR_W-1:0]  region_end;
    logic [mrt_pkg::KIND_W-1:0]  region_kind;
    logic [mrt_pkg::ADDR_W-1:0]  query_addr;

    modport source (output valid, mode, region_start, region_end, region_kind, query_addr,
                    input ready);
    modport sink   (input valid, mode, region_start, region_end, region_kind, query_addr,
                    output ready);
endinterface

interface mrt_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [mrt_pkg::KIND_W-1:0]  found_kind;
    logic                        is_reserved;
    logic                        insert_rejected;

    modport source (output valid, found_kind, is_reserved, insert_rejected, input ready);
    modport sink   (input valid, found_kind, is_reserved, insert_rejected, output ready);
endinterface

interface mrt_cfg_if;
    logic valid;
    logic ready;
    logic map_present;

    modport source (output valid, map_present, input ready);
    modport sink   (input valid, map_present, output ready);
endinterface

// ----- sv/memory_region_type_table_unit.sv -----
// Memory region type table top level: joins controller, datapath and channel interfaces.
// Depends on mrt_pkg, mrt_if, mrt_ctrl and mrt_datapath.
//
//   port  | interface  | role   | carries
//   ------+------------+--------+----------------------------------------------------
//   req   | mrt_req_if | sink   | mode, region_start, region_end, region_kind, query_addr
//   rsp   | mrt_rsp_if | source | found_kind, is_reserved, insert_rejected
//   cfg   | mrt_cfg_if | sink   | map_present (always ready)
//
// One item at a time; the table sits in a memory read one entry per cycle.
// Clear, mode 3, a rejected insert and a lookup without a map go straight to the result;
// a lookup scans entries up to the first match; an insert shifts up each entry at or above
// the insertion point and then writes the new entry.
// The next item is accepted in the cycle after a result is loaded, even while it waits.
// A stalled result holds the following one and stalls the input; reset empties the table.
module memory_region_type_table_unit (
    input  logic clk,
    input  logic rst_n,
    mrt_req_if.sink   req,
    mrt_rsp_if.source rsp,
    mrt_cfg_if.sink   cfg
);

    mrt_pkg::cmd_t    cmd;
    mrt_pkg::status_t st;

    assign cfg.ready = 1'b1;

    mrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .st        (st),
        .cmd       (cmd)
    );

    mrt_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg.valid),
        .cfg_map_present (cfg.map_present),
        .mode            (req.mode),
        .region_start    (req.region_start),
        .region_end      (req.region_end),
        .region_kind     (req.region_kind),
        .query_addr      (req.query_addr),
        .rsp_ready       (rsp.ready),
        .cmd             (cmd),
        .st              (st),
        .rsp_valid       (rsp.valid),
        .found_kind      (rsp.found_kind),
        .is_reserved     (rsp.is_reserved),
        .insert_rejected (rsp.insert_rejected)
    );

endmodule

// ----- sv/mrt_datapath.sv -----
// Memory region type table datapath: region memory, scan pointer, item and result registers.
// Driven by mrt_ctrl through mrt_pkg::cmd_t; depends on mrt_pkg.
module mrt_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_map_present,
    input  logic [1:0]                  mode,
    input  logic [mrt_pkg::ADDR_W-1:0]  region_start,
    input  logic [mrt_pkg::ADDR_W-1:0]  region_end,
    input  logic [mrt_pkg::KIND_W-1:0]  region_kind,
    input  logic [mrt_pkg::ADDR_W-1:0]  query_addr,
    input  logic                        rsp_ready,
    input  mrt_pkg::cmd_t               cmd,
    output mrt_pkg::status_t            st,
    output logic                        rsp_valid,
    output logic [mrt_pkg::KIND_W-1:0]  found_kind,
    output logic                        is_reserved,
    output logic                        insert_rejected
);

    mrt_pkg::entry_t                mem [mrt_pkg::MAX_REGIONS];
    mrt_pkg::entry_t                rd_data_reg;

    logic                           map_present_reg;
    logic [mrt_pkg::CNT_W-1:0]      count_reg,  count_next;
    logic [mrt_pkg::CNT_W-1:0]      ptr_reg,    ptr_next;
    logic                           live_reg,   live_next;
    logic [mrt_pkg::KIND_W-1:0]     found_reg,  found_next;
    logic                           rej_reg;

    logic [1:0]                     mode_reg;
    mrt_pkg::entry_t                new_reg;
    logic [mrt_pkg::ADDR_W-1:0]     addr_reg;

    logic                           out_valid_reg;
    logic [mrt_pkg::KIND_W-1:0]     out_kind_reg;
    logic                           out_res_reg;
    logic                           out_rej_reg;

    logic                           rd_en;
    logic [mrt_pkg::IDX_W-1:0]      rd_addr;
    logic                           wr_en;
    logic [mrt_pkg::IDX_W-1:0]      wr_addr;
    mrt_pkg::entry_t                wr_data;
    logic                           done;
    logic                           full;
    logic                           hit;
    logic                           in_window;
    logic                           is_lookup;
    logic [mrt_pkg::CNT_W-1:0]      ptr_dec1;
    logic [mrt_pkg::CNT_W-1:0]      ptr_dec2;

    assign full      = (count_reg == mrt_pkg::CNT_W'(mrt_pkg::MAX_REGIONS));
    assign ptr_dec1  = ptr_reg - mrt_pkg::CNT_W'(1);
    assign ptr_dec2  = ptr_reg - mrt_pkg::CNT_W'(2);
    assign hit       = (rd_data_reg.start_addr <= addr_reg) && (rd_data_reg.end_addr > addr_reg);
    assign in_window = (addr_reg >= mrt_pkg::LOW_WIN_FIRST) && (addr_reg <= mrt_pkg::LOW_WIN_LAST);
    assign is_lookup = (mode_reg == mrt_pkg::MODE_LOOKUP);

    assign st.go_insert = (mode == mrt_pkg::MODE_INSERT) && !full;
    assign st.go_lookup = (mode == mrt_pkg::MODE_LOOKUP) && map_present_reg;
    assign st.step_done = done;
    assign st.out_free  = !out_valid_reg || rsp_ready;

    always_comb
    begin
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = new_reg;
        done       = 1'b0;
        ptr_next   = ptr_reg;
        live_next  = live_reg;
        found_next = found_reg;
        count_next = count_reg;

        if (cmd.capture && (mode == mrt_pkg::MODE_CLEAR))
        begin
            count_next = '0;
        end

        if (cmd.ins_begin)
        begin
            ptr_next  = count_reg;
            live_next = 1'b0;
        end
        else if (cmd.lkp_begin)
        begin
            ptr_next  = '0;
            live_next = 1'b0;
        end
        else if (cmd.ins_step)
        begin
            if (!live_reg)
            begin
                if (ptr_reg == '0)
                begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    done    = 1'b1;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = ptr_dec1[mrt_pkg::IDX_W-1:0];
                    live_next = 1'b1;
                end
            end
            else if (rd_data_reg.start_addr <= new_reg.start_addr)
            begin
                wr_en     = 1'b1;
                wr_addr   = ptr_reg[mrt_pkg::IDX_W-1:0];
                done      = 1'b1;
                live_next = 1'b0;
            end
            else
            begin
                // shift the larger entry up one place
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[mrt_pkg::IDX_W-1:0];
                wr_data  = rd_data_reg;
                ptr_next = ptr_dec1;
                if (ptr_reg == mrt_pkg::CNT_W'(1))
                begin
                    live_next = 1'b0;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_dec2[mrt_pkg::IDX_W-1:0];
                end
            end
            if (done)
            begin
                count_next = count_reg + mrt_pkg::CNT_W'(1);
            end
        end
        else if (cmd.lkp_step)
        begin
            if (!live_reg)
            begin
                if (count_reg == '0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = '0;
                    ptr_next  = mrt_pkg::CNT_W'(1);
                    live_next = 1'b1;
                end
            end
            else if (hit)
            begin
                found_next = rd_data_reg.kind;
                done       = 1'b1;
                live_next  = 1'b0;
            end
            else if (ptr_reg == count_reg)
            begin
                done      = 1'b1;
                live_next = 1'b0;
            end
            else
            begin
                rd_en    = 1'b1;
                rd_addr  = ptr_reg[mrt_pkg::IDX_W-1:0];
                ptr_next = ptr_reg + mrt_pkg::CNT_W'(1);
            end
        end

        if (cmd.capture)
        begin
            found_next = mrt_pkg::KIND_UNKNOWN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg           <= mode;
            new_reg.start_addr <= region_start;
            new_reg.end_addr   <= region_end;
            new_reg.kind       <= region_kind;
            addr_reg           <= query_addr;
        end
        if (cmd.load_out)
        begin
            out_kind_reg <= (is_lookup && map_present_reg) ? found_reg : mrt_pkg::KIND_UNKNOWN;
            out_res_reg  <= is_lookup && (!map_present_reg || in_window ||
                            (found_reg == mrt_pkg::KIND_RESERVED) ||
                            (found_reg == mrt_pkg::KIND_ACPI));
            out_rej_reg  <= rej_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_present_reg <= 1'b0;
            count_reg       <= '0;
            ptr_reg         <= '0;
            live_reg        <= 1'b0;
            found_reg       <= mrt_pkg::KIND_UNKNOWN;
            rej_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                map_present_reg <= cfg_map_present;
            end
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            live_reg  <= live_next;
            found_reg <= found_next;
            if (cmd.capture)
            begin
                rej_reg <= (mode == mrt_pkg::MODE_INSERT) && full;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign found_kind      = out_kind_reg;
    assign is_reserved     = out_res_reg;
    assign insert_rejected = out_rej_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mrt_pkg::CNT_W'(mrt_pkg::MAX_REGIONS))
        else $error("region count beyond table depth");

    a_write_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> cmd.ins_step)
        else $error("table written outside an insert");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_step |-> (ptr_reg <= count_reg) && !full)
        else $error("insert pointer beyond table fill");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || rsp_ready))
        else $error("result register overwritten while held");
`endif

endmodule

// ----- sv/mrt_ctrl.sv -----
// Memory region type table controller: state machine that sequences insert and lookup scans.
// Drives mrt_datapath through mrt_pkg::cmd_t; depends on mrt_pkg.
module mrt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  mrt_pkg::status_t  st,
    output mrt_pkg::cmd_t     cmd
);

    mrt_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mrt_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    if (st.go_insert)
                    begin
                        state_next = mrt_pkg::S_INSERT;
                    end
                    else if (st.go_lookup)
                    begin
                        state_next = mrt_pkg::S_LOOKUP;
                    end
                    else
                    begin
                        state_next = mrt_pkg::S_DONE;
                    end
                end
            end
            mrt_pkg::S_INSERT,
            mrt_pkg::S_LOOKUP:
            begin
                if (st.step_done)
                begin
                    state_next = mrt_pkg::S_DONE;
                end
            end
            mrt_pkg::S_DONE:
            begin
                if (st.out_free)
                begin
                    state_next = mrt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mrt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            mrt_pkg::S_IDLE:
            begin
                req_ready     = 1'b1;
                cmd.capture   = req_valid;
                cmd.ins_begin = req_valid && st.go_insert;
                cmd.lkp_begin = req_valid && !st.go_insert && st.go_lookup;
            end
            mrt_pkg::S_INSERT:
            begin
                cmd.ins_step = 1'b1;
            end
            mrt_pkg::S_LOOKUP:
            begin
                cmd.lkp_step = 1'b1;
            end
            mrt_pkg::S_DONE:
            begin
                cmd.load_out = st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- bench/region_table_checker.sv -----
// Region table checker: watches the item, result and map_present channels of the
// memory region type table, predicts every result and compares it field by field.
// Depends on mrt_pkg and the channel interfaces in mrt_if.
`timescale 1ns / 100ps
module region_table_checker (
    input  logic clk,
    input  logic rst_n,
    mrt_req_if   req,
    mrt_rsp_if   rsp,
    mrt_cfg_if   cfg,
    output int   mismatches,
    output int   outstanding
);

    typedef struct packed {
        logic [mrt_pkg::KIND_W-1:0] found_kind;
        logic                       is_reserved;
        logic                       insert_rejected;
    } region_result_t;

    logic [mrt_pkg::ADDR_W-1:0] tbl_start [mrt_pkg::MAX_REGIONS];
    logic [mrt_pkg::ADDR_W-1:0] tbl_end   [mrt_pkg::MAX_REGIONS];
    logic [mrt_pkg::KIND_W-1:0] tbl_kind  [mrt_pkg::MAX_REGIONS];
    int                         tbl_count;
    logic                       map_on;
    region_result_t             due_results [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        tbl_count   = 0;
        map_on      = 1'b0;
    end

    function automatic region_result_t apply_item(
        input logic [1:0]                 mode,
        input logic [mrt_pkg::ADDR_W-1:0] s,
        input logic [mrt_pkg::ADDR_W-1:0] e,
        input logic [mrt_pkg::KIND_W-1:0] k,
        input logic [mrt_pkg::ADDR_W-1:0] addr
    );
        region_result_t r;
        int             pos;
        logic           hit;
        r   = '0;
        pos = 0;
        hit = 1'b0;
        case (mode)
            mrt_pkg::MODE_INSERT:
            begin
                if (tbl_count >= mrt_pkg::MAX_REGIONS)
                begin
                    r.insert_rejected = 1'b1;
                end
                else
                begin
                    while (pos < tbl_count && tbl_start[pos] <= s)
                        pos++;
                    for (int i = tbl_count; i > pos; i--)
                    begin
                        tbl_start[i] = tbl_start[i-1];
                        tbl_end[i]   = tbl_end[i-1];
                        tbl_kind[i]  = tbl_kind[i-1];
                    end
                    tbl_start[pos] = s;
                    tbl_end[pos]   = e;
                    tbl_kind[pos]  = k;
                    tbl_count++;
                end
            end
            mrt_pkg::MODE_LOOKUP:
            begin
                if (!map_on)
                begin
                    r.is_reserved = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < tbl_count && !hit; i++)
                    begin
                        if (tbl_start[i] <= addr && addr < tbl_end[i])
                        begin
                            r.found_kind = tbl_kind[i];
                            hit          = 1'b1;
                        end
                    end
                    r.is_reserved = (addr >= mrt_pkg::LOW_WIN_FIRST
                                     && addr <= mrt_pkg::LOW_WIN_LAST)
                                  || r.found_kind == mrt_pkg::KIND_RESERVED
                                  || r.found_kind == mrt_pkg::KIND_ACPI;
                end
            end
            mrt_pkg::MODE_CLEAR:
            begin
                tbl_count = 0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
        $display("MISMATCH at %0t: %s expected %0h got %0h", $time, what, want, got);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        region_result_t want;
        if (!rst_n)
        begin
            tbl_count = 0;
            map_on    = 1'b0;
            due_results.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                map_on = cfg.map_present;
            if (req.valid && req.ready)
                due_results.push_back(apply_item(req.mode, req.region_start, req.region_end,
                                                 req.region_kind, req.query_addr));
            if (rsp.valid && rsp.ready)
            begin
                if (due_results.size() == 0)
                begin
                    note_mismatch("result with nothing outstanding", 8'h0, 8'h0);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (rsp.found_kind !== want.found_kind)
                        note_mismatch("found_kind", 8'(want.found_kind), 8'(rsp.found_kind));
                    if (rsp.is_reserved !== want.is_reserved)
                        note_mismatch("is_reserved", 8'(want.is_reserved),
                                      8'(rsp.is_reserved));
                    if (rsp.insert_rejected !== want.insert_rejected)
                        note_mismatch("insert_rejected", 8'(want.insert_rejected),
                                      8'(rsp.insert_rejected));
                end
            end
        end
        outstanding = due_results.size();
    end

endmodule

// ----- bench/memory_region_type_table_unit_tb.sv -----
// Testbench top for the memory region type table: clock, reset, item and map_present
// stimulus, receiver stalls and the verdict. Depends on mrt_pkg, mrt_if,
// region_table_checker and the block memory_region_type_table_unit.
`timescale 1ns / 100ps
module memory_region_type_table_unit_tb;

    localparam logic [1:0]                 MODE_UNUSED = 2'd3;
    localparam logic [mrt_pkg::KIND_W-1:0] KIND_USABLE = 2'd1;
    localparam logic [mrt_pkg::ADDR_W-1:0] ADDR_MAX    = '1;
    localparam int                         NUM_PHASES  = 8;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   items_sent;
    int   burst_left;
    int   idle_style;
    int   map_writes;
    int   long_holds;
    int   mode_tally [4];

    logic [mrt_pkg::ADDR_W-1:0] seen_bounds [$];

    mrt_req_if req_ch();
    mrt_rsp_if rsp_ch();
    mrt_cfg_if cfg_ch();

    memory_region_type_table_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    region_table_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("memory_region_type_table_unit verification failed");
        $finish;
    end

    // receiver: changing stall patterns, plus long hold-offs while items keep coming
    initial
    begin
        int hold;
        int style_left;
        int stall_pct;
        int next_hold_at;
        rsp_ch.ready = 1'b0;
        hold         = 0;
        style_left   = 0;
        stall_pct    = 0;
        next_hold_at = 300;
        forever
        begin
            @(negedge clk);
            if (hold == 0 && items_sent >= next_hold_at)
            begin
                hold         = 250;
                next_hold_at = next_hold_at + 700;
                long_holds++;
            end
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold--;
            end
            else
            begin
                if (style_left == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       stall_pct = 0;
                        1:       stall_pct = 30;
                        default: stall_pct = 70;
                    endcase
                    style_left = $urandom_range(20, 200);
                end
                style_left--;
                rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    function automatic logic [mrt_pkg::ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic offer_item(
        input logic [1:0]                 mode,
        input logic [mrt_pkg::ADDR_W-1:0] s,
        input logic [mrt_pkg::ADDR_W-1:0] e,
        input logic [mrt_pkg::KIND_W-1:0] k,
        input logic [mrt_pkg::ADDR_W-1:0] addr
    );
        int gap;
        if (burst_left == 0)
        begin
            gap = (idle_style == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                req_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= mode;
        req_ch.region_start <= s;
        req_ch.region_end   <= e;
        req_ch.region_kind  <= k;
        req_ch.query_addr   <= addr;
        do @(posedge clk); while (!req_ch.ready);
        items_sent++;
        mode_tally[mode]++;
    endtask

    task automatic send_insert(input logic [mrt_pkg::ADDR_W-1:0] s,
                               input logic [mrt_pkg::ADDR_W-1:0] e,
                               input logic [mrt_pkg::KIND_W-1:0] k);
        offer_item(mrt_pkg::MODE_INSERT, s, e, k, rand64());
        if (seen_bounds.size() < 64)
        begin
            seen_bounds.push_back(s);
            seen_bounds.push_back(e);
        end
    endtask

    task automatic send_lookup(input logic [mrt_pkg::ADDR_W-1:0] addr);
        offer_item(mrt_pkg::MODE_LOOKUP, rand64(), rand64(),
                   mrt_pkg::KIND_W'($urandom_range(0, 3)), addr);
    endtask

    task automatic send_clear();
        offer_item(mrt_pkg::MODE_CLEAR, rand64(), rand64(),
                   mrt_pkg::KIND_W'($urandom_range(0, 3)), rand64());
        seen_bounds.delete();
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic set_map(input logic on);
        drain_results();
        @(negedge clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.map_present <= on;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        map_writes++;
    endtask

    task automatic make_region(output logic [mrt_pkg::ADDR_W-1:0] s,
                               output logic [mrt_pkg::ADDR_W-1:0] e);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            s = mrt_pkg::ADDR_W'($urandom_range(0, 4 * 1024 * 1024));
            e = s + mrt_pkg::ADDR_W'($urandom_range(1, 512 * 1024));
        end
        else if (pick < 70 && seen_bounds.size() > 0)
        begin
            s = seen_bounds[$urandom_range(0, seen_bounds.size() - 1)];
            e = s + mrt_pkg::ADDR_W'($urandom_range(1, 64 * 1024));
        end
        else if (pick < 80)
        begin
            e = mrt_pkg::ADDR_W'($urandom_range(0, 4 * 1024 * 1024));
            s = e + mrt_pkg::ADDR_W'($urandom_range(0, 4096));
        end
        else if (pick < 90)
        begin
            s = rand64();
            e = rand64();
        end
        else
        begin
            s = ADDR_MAX - mrt_pkg::ADDR_W'($urandom_range(0, 1024));
            e = ADDR_MAX - mrt_pkg::ADDR_W'($urandom_range(0, 2));
        end
    endtask

    function automatic logic [mrt_pkg::ADDR_W-1:0] pick_addr();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40 && seen_bounds.size() > 0)
            return seen_bounds[$urandom_range(0, seen_bounds.size() - 1)]
                   + mrt_pkg::ADDR_W'($urandom_range(0, 2)) - mrt_pkg::ADDR_W'(1);
        else if (pick < 55)
            case ($urandom_range(0, 3))
                0:       return mrt_pkg::LOW_WIN_FIRST - mrt_pkg::ADDR_W'(1);
                1:       return mrt_pkg::LOW_WIN_FIRST;
                2:       return mrt_pkg::LOW_WIN_LAST;
                default: return mrt_pkg::LOW_WIN_LAST + mrt_pkg::ADDR_W'(1);
            endcase
        else if (pick < 75)
            return mrt_pkg::ADDR_W'($urandom_range(0, 4 * 1024 * 1024));
        else if (pick < 90)
            return rand64();
        else
            return ($urandom_range(0, 1) != 0) ? ADDR_MAX : '0;
    endfunction

    // one region map build-up: usually a clear, then inserts and lookups interleaved with occasional random items
    task automatic run_sequence(input bit fill);
        int                         n_ins;
        int                         n_lkp;
        logic [mrt_pkg::ADDR_W-1:0] s;
        logic [mrt_pkg::ADDR_W-1:0] e;
        if (fill || $urandom_range(0, 3) != 0)
            send_clear();
        if (fill)
            n_ins = 35;
        else if ($urandom_range(0, 3) == 0)
            n_ins = $urandom_range(33, 36);
        else
            n_ins = $urandom_range(0, 12);
        n_lkp = $urandom_range(4, 30);
        while (n_ins > 0 || n_lkp > 0)
        begin
            if ($urandom_range(0, 99) < 6)
            begin
                offer_item(2'($urandom_range(0, 3)), rand64(), rand64(),
                           mrt_pkg::KIND_W'($urandom_range(0, 3)), rand64());
            end
            else if (n_ins > 0 && (n_lkp == 0 || $urandom_range(0, 99) < 60))
            begin
                make_region(s, e);
                send_insert(s, e, mrt_pkg::KIND_W'($urandom_range(0, 3)));
                n_ins--;
            end
            else
            begin
                send_lookup(pick_addr());
                n_lkp--;
            end
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.mode         = mrt_pkg::MODE_INSERT;
        req_ch.region_start = '0;
        req_ch.region_end   = '0;
        req_ch.region_kind  = '0;
        req_ch.query_addr   = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.map_present  = 1'b0;
        items_sent          = 0;
        burst_left          = 0;
        idle_style          = 0;
        map_writes          = 0;
        long_holds          = 0;
        mode_tally          = '{default: 0};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // no map: every lookup is reserved whatever the table holds
        set_map(1'b0);
        send_lookup('0);
        send_insert('0, ADDR_MAX, KIND_USABLE);
        send_insert(ADDR_MAX, '0, mrt_pkg::KIND_RESERVED);
        send_insert(mrt_pkg::LOW_WIN_FIRST, mrt_pkg::LOW_WIN_FIRST, mrt_pkg::KIND_ACPI);
        send_lookup(mrt_pkg::LOW_WIN_FIRST);
        offer_item(MODE_UNUSED, ADDR_MAX, ADDR_MAX, '1, ADDR_MAX);

        set_map(1'b1);
        send_lookup('0);
        send_lookup(ADDR_MAX);
        send_lookup(mrt_pkg::LOW_WIN_FIRST - mrt_pkg::ADDR_W'(1));
        send_lookup(mrt_pkg::LOW_WIN_FIRST);
        send_lookup(mrt_pkg::LOW_WIN_LAST);
        send_lookup(mrt_pkg::LOW_WIN_LAST + mrt_pkg::ADDR_W'(1));
        send_insert('0, 64'd4096, mrt_pkg::KIND_ACPI);
        send_lookup(64'd100);
        send_insert(64'd2000, 64'd3000, mrt_pkg::KIND_RESERVED);
        send_lookup(64'd2500);
        send_clear();
        send_lookup(64'd2500);
        send_insert(64'd100, 64'd200, mrt_pkg::KIND_ACPI);
        send_insert(64'd100, 64'd300, KIND_USABLE);
        send_lookup(64'd150);
        send_lookup(64'd250);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            set_map((phase % 3) != 2);
            idle_style = phase % 3;
            run_sequence(phase == 0);
            while (items_sent < 25 + (phase + 1) * 210)
            begin
                if ((phase % 2) == 1 && items_sent >= 25 + phase * 210 + 105
                    && items_sent < 25 + phase * 210 + 110)
                    drain_results();
                run_sequence(1'b0);
            end
        end
        set_map(1'b0);

        drain_results();
        repeat (40) @(negedge clk);
        $display("covered %0d items: %0d inserts, %0d lookups, %0d clears, %0d unused mode",
                 items_sent, mode_tally[mrt_pkg::MODE_INSERT], mode_tally[mrt_pkg::MODE_LOOKUP],
                 mode_tally[mrt_pkg::MODE_CLEAR], mode_tally[MODE_UNUSED]);
        $display("map_present written %0d times; %0d long result hold-offs; %0d mismatches",
                 map_writes, long_holds, mismatches);
        if (mismatches == 0)
            $display("memory_region_type_table_unit verification clean");
        else
            $display("memory_region_type_table_unit verification failed");
        $finish;
    end

endmodule
